FILE: hdl/gpse_pkg.sv
// Shared types, constants and helper functions for the greyscale PNG stored encoder.
// Used by gpse_front, gpse_back and greyscale_png_stored_encoder. No dependencies.
package gpse_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int DIM_W           = 15;
   localparam int CNT_W           = 14;
   localparam logic [DIM_W-1:0] MAX_DIM = 15'd16384;
   localparam logic [16:0] ADLER_MOD = 17'd65521;
   localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
   localparam logic [31:0] IEND_CRC  = 32'hAE426082;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_DEPTH  = 2'd2;

   typedef enum logic [1:0] {PH_IDLE, PH_PIXELS, PH_DONE} phase_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CALC1, ST_CALC2, ST_CALC3, ST_HDR, ST_BHDR, ST_NEXT, ST_RAW, ST_FIN
   } state_type;

   typedef struct packed {
      logic       action;
      logic [7:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       file_end;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } queue_head_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [1:0]       depth_code;
   } cfg_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = 15'd1;
      else if (v > MAX_DIM) r = MAX_DIM;
      return r;
   endfunction

endpackage

FILE: hdl/gpse_front.sv
// Input side of the encoder: accepts transactions into a short queue.
// Depends on gpse_pkg.
module gpse_front import gpse_pkg::*; #(
   parameter int QDEPTH = QUEUE_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type        req_payload,
   output queue_head_type head,
   input  logic           pop
);
   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CW = $clog2(QDEPTH + 1);

   req_type         mem_ff [QDEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push, do_pop;

   assign req_stall  = (count_ff == CW'(QDEPTH));
   assign push       = req_valid && !req_stall;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff + CW'(push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= req_payload;
   end

endmodule

FILE: hdl/gpse_back.sv
// Byte sequencer of the encoder: headers, packing, stored blocks, checksums, trailer.
// Depends on gpse_pkg; fed by gpse_front.
module gpse_back import gpse_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   input  cfg_type        cfg,
   output phase_type      phase,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp_payload
);
   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic [DIM_W-1:0] w_ff, w_in, h_ff, h_in;
   logic [1:0]       dc_ff, dc_in;
   logic [DIM_W-1:0] stride_ff, stride_in;
   logic [28:0]      raw_ff, raw_in;
   logic [31:0]      idat_len_ff, idat_len_in;
   logic [31:0]      crc_ff, crc_in;
   logic [15:0]      alow_ff, alow_in, ahigh_ff, ahigh_in;
   logic [CNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [7:0]       pb_ff, pb_in;
   logic [2:0]       bitpos_ff, bitpos_in;
   logic [15:0]      blk_left_ff, blk_left_in;
   logic [28:0]      raw_left_ff, raw_left_in;
   logic [5:0]       idx_ff, idx_in;
   logic             hdr_start_ff, hdr_start_in;
   logic             filt_ff, filt_in, pack_ff, pack_in, tail_ff, tail_in, fin_ff, fin_in;
   logic [7:0]       pack_byte_ff, pack_byte_in, tail_byte_ff, tail_byte_in;
   logic [7:0]       cur_ff, cur_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic        go, emit, e_last, e_end;
   logic [7:0]  e_byte;
   // start-of-image arithmetic
   logic [17:0] wsh;
   logic [29:0] prod, xr;
   logic [13:0] qa, blocks;
   logic [16:0] qs;
   // pixel packing
   logic [3:0]  bits, sh, npos;
   logic [7:0]  mask, npb, pb_after;
   logic [2:0]  pos_after;
   logic        do_pack, rowend, lastrow;
   logic [DIM_W-1:0] col_next, row_next;
   // block header and adler
   logic [15:0] blen;
   logic [16:0] lsum, hsum;
   logic [15:0] lnew;

   assign go          = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign phase       = phase_ff;

   always_comb begin
      wsh      = {3'd0, w_ff} << dc_ff;
      prod     = {15'd0, h_ff} * {15'd0, stride_ff + 15'd1};
      xr       = {1'b0, raw_ff} + 30'd65534;
      qa       = xr[29:16];
      qs       = {3'd0, qa} + {1'b0, xr[15:0]};
      blocks   = qa + 14'(qs >= 17'd65535);

      bits     = 4'd1 << dc_ff;
      mask     = 8'hFF >> (4'd8 - bits);
      sh       = 4'd8 - bits - {1'b0, bitpos_ff};
      npb      = pb_ff | ((head.item.pixel_value & mask) << sh[2:0]);
      npos     = {1'b0, bitpos_ff} + bits;
      do_pack  = npos >= 4'd8;
      pb_after = do_pack ? 8'd0 : npb;
      pos_after = do_pack ? 3'd0 : npos[2:0];
      col_next = {1'b0, col_ff} + 15'd1;
      row_next = {1'b0, row_ff} + 15'd1;
      rowend   = col_next >= w_ff;
      lastrow  = row_next >= h_ff;

      blen     = (raw_left_ff < 29'd65535) ? raw_left_ff[15:0] : 16'hFFFF;
      lsum     = {1'b0, alow_ff} + {9'd0, cur_ff};
      lnew     = (lsum >= ADLER_MOD) ? 16'(lsum - ADLER_MOD) : lsum[15:0];
      hsum     = {1'b0, ahigh_ff} + {1'b0, lnew};
   end

   always_comb begin
      state_in = state_ff;   phase_in = phase_ff;
      w_in = w_ff; h_in = h_ff; dc_in = dc_ff;
      stride_in = stride_ff; raw_in = raw_ff; idat_len_in = idat_len_ff;
      crc_in = crc_ff; alow_in = alow_ff; ahigh_in = ahigh_ff;
      col_in = col_ff; row_in = row_ff; pb_in = pb_ff; bitpos_in = bitpos_ff;
      blk_left_in = blk_left_ff; raw_left_in = raw_left_ff;
      idx_in = idx_ff; hdr_start_in = hdr_start_ff;
      filt_in = filt_ff; pack_in = pack_ff; tail_in = tail_ff; fin_in = fin_ff;
      pack_byte_in = pack_byte_ff; tail_byte_in = tail_byte_ff; cur_in = cur_ff;
      pop = 1'b0;
      emit = 1'b0; e_byte = 8'd0; e_last = 1'b0; e_end = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.item.action == ACT_START) begin
                  w_in = eff_dim(cfg.width);
                  h_in = eff_dim(cfg.height);
                  dc_in = cfg.depth_code;
                  phase_in = PH_PIXELS;
                  state_in = ST_CALC1;
               end else if (phase_ff == PH_PIXELS) begin
                  filt_in = (col_ff == '0);
                  pack_in = do_pack;
                  pack_byte_in = npb;
                  tail_in = rowend && (pos_after != 3'd0);
                  tail_byte_in = pb_after;
                  fin_in = rowend && lastrow;
                  if (rowend) begin
                     pb_in = 8'd0; bitpos_in = 3'd0; col_in = '0;
                     row_in = row_next[CNT_W-1:0];
                  end else begin
                     pb_in = pb_after; bitpos_in = pos_after;
                     col_in = col_next[CNT_W-1:0];
                  end
                  state_in = ST_NEXT;
               end
            end
         end
         ST_CALC1: begin
            stride_in = wsh[17:3] + 15'(wsh[2:0] != 3'd0);
            state_in = ST_CALC2;
         end
         ST_CALC2: begin
            raw_in = prod[28:0];
            state_in = ST_CALC3;
         end
         ST_CALC3: begin
            idat_len_in = 32'(raw_ff) + 32'(blocks) * 32'd5 + 32'd6;
            raw_left_in = raw_ff;
            alow_in = 16'd1; ahigh_in = 16'd0;
            col_in = '0; row_in = '0; pb_in = 8'd0; bitpos_in = 3'd0;
            idx_in = 6'd0;
            state_in = ST_HDR;
         end
         ST_HDR: begin
            emit = 1'b1;
            case (idx_ff) inside
               6'd0: e_byte = 8'h89;
               6'd1: e_byte = 8'h50;
               6'd2: e_byte = 8'h4E;
               6'd3: e_byte = 8'h47;
               6'd4: e_byte = 8'h0D;
               6'd5: e_byte = 8'h0A;
               6'd6: e_byte = 8'h1A;
               6'd7: e_byte = 8'h0A;
               6'd11: e_byte = 8'h0D;
               6'd12: e_byte = 8'h49;
               6'd13: e_byte = 8'h48;
               6'd14: e_byte = 8'h44;
               6'd15: e_byte = 8'h52;
               6'd18: e_byte = {1'b0, w_ff[14:8]};
               6'd19: e_byte = w_ff[7:0];
               6'd22: e_byte = {1'b0, h_ff[14:8]};
               6'd23: e_byte = h_ff[7:0];
               6'd24: e_byte = {4'd0, bits};
               6'd29: e_byte = ~crc_ff[31:24];
               6'd30: e_byte = ~crc_ff[23:16];
               6'd31: e_byte = ~crc_ff[15:8];
               6'd32: e_byte = ~crc_ff[7:0];
               6'd33: e_byte = idat_len_ff[31:24];
               6'd34: e_byte = idat_len_ff[23:16];
               6'd35: e_byte = idat_len_ff[15:8];
               6'd36: e_byte = idat_len_ff[7:0];
               6'd37: e_byte = 8'h49;
               6'd38: e_byte = 8'h44;
               6'd39: e_byte = 8'h41;
               6'd40: e_byte = 8'h54;
               6'd41: e_byte = 8'h78;
               6'd42: e_byte = 8'h01;
               default: e_byte = 8'h00;
            endcase
            if (go) begin
               // IHDR and IDAT chunk CRCs each restart from all ones
               if (idx_ff == 6'd12 || idx_ff == 6'd37)
                  crc_in = crc_byte(32'hFFFFFFFF, e_byte);
               else if ((idx_ff > 6'd12 && idx_ff <= 6'd28) || idx_ff > 6'd37)
                  crc_in = crc_byte(crc_ff, e_byte);
               if (idx_ff == 6'd42) begin
                  idx_in = 6'd0;
                  hdr_start_in = 1'b1;
                  state_in = ST_BHDR;
               end else begin
                  idx_in = idx_ff + 6'd1;
               end
            end
         end
         ST_BHDR: begin
            emit = 1'b1;
            case (idx_ff)
               6'd0: e_byte = {7'd0, raw_left_ff <= 29'd65535};
               6'd1: e_byte = blen[7:0];
               6'd2: e_byte = blen[15:8];
               6'd3: e_byte = ~blen[7:0];
               default: e_byte = ~blen[15:8];
            endcase
            e_last = (idx_ff == 6'd4) && hdr_start_ff;
            if (go) begin
               crc_in = crc_byte(crc_ff, e_byte);
               if (idx_ff == 6'd4) begin
                  blk_left_in = blen;
                  idx_in = 6'd0;
                  state_in = hdr_start_ff ? ST_IDLE : ST_RAW;
               end else begin
                  idx_in = idx_ff + 6'd1;
               end
            end
         end
         ST_NEXT: begin
            if (filt_ff || pack_ff || tail_ff) begin
               if (filt_ff) begin
                  cur_in = 8'd0; filt_in = 1'b0;
               end else if (pack_ff) begin
                  cur_in = pack_byte_ff; pack_in = 1'b0;
               end else begin
                  cur_in = tail_byte_ff; tail_in = 1'b0;
               end
               hdr_start_in = 1'b0;
               idx_in = 6'd0;
               state_in = (blk_left_ff == 16'd0) ? ST_BHDR : ST_RAW;
            end else if (fin_ff) begin
               idx_in = 6'd0;
               state_in = ST_FIN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RAW: begin
            emit = 1'b1;
            e_byte = cur_ff;
            e_last = !filt_ff && !pack_ff && !tail_ff && !fin_ff;
            if (go) begin
               crc_in = crc_byte(crc_ff, cur_ff);
               alow_in = lnew;
               ahigh_in = (hsum >= ADLER_MOD) ? 16'(hsum - ADLER_MOD) : hsum[15:0];
               blk_left_in = blk_left_ff - 16'd1;
               raw_left_in = raw_left_ff - 29'd1;
               state_in = ST_NEXT;
            end
         end
         ST_FIN: begin
            emit = 1'b1;
            case (idx_ff)
               6'd0: e_byte = ahigh_ff[15:8];
               6'd1: e_byte = ahigh_ff[7:0];
               6'd2: e_byte = alow_ff[15:8];
               6'd3: e_byte = alow_ff[7:0];
               6'd4: e_byte = ~crc_ff[31:24];
               6'd5: e_byte = ~crc_ff[23:16];
               6'd6: e_byte = ~crc_ff[15:8];
               6'd7: e_byte = ~crc_ff[7:0];
               6'd12: e_byte = 8'h49;
               6'd13: e_byte = 8'h45;
               6'd14: e_byte = 8'h4E;
               6'd15: e_byte = 8'h44;
               6'd16: e_byte = IEND_CRC[31:24];
               6'd17: e_byte = IEND_CRC[23:16];
               6'd18: e_byte = IEND_CRC[15:8];
               6'd19: e_byte = IEND_CRC[7:0];
               default: e_byte = 8'h00;
            endcase
            e_last = (idx_ff == 6'd19);
            e_end  = (idx_ff == 6'd19);
            if (go) begin
               if (idx_ff < 6'd4) crc_in = crc_byte(crc_ff, e_byte);
               if (idx_ff == 6'd19) begin
                  fin_in = 1'b0;
                  phase_in = PH_DONE;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 6'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      if (emit && go) begin
         rsp_valid_in = 1'b1;
         rsp_in.out_byte = e_byte;
         rsp_in.run_last = e_last;
         rsp_in.file_end = e_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
         crc_ff <= 32'hFFFFFFFF;
         alow_ff <= 16'd1;
         ahigh_ff <= 16'd0;
         col_ff <= '0;
         row_ff <= '0;
         pb_ff <= 8'd0;
         bitpos_ff <= 3'd0;
         blk_left_ff <= 16'd0;
         raw_left_ff <= 29'd0;
         idx_ff <= 6'd0;
         hdr_start_ff <= 1'b0;
         filt_ff <= 1'b0;
         pack_ff <= 1'b0;
         tail_ff <= 1'b0;
         fin_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         crc_ff <= crc_in;
         alow_ff <= alow_in;
         ahigh_ff <= ahigh_in;
         col_ff <= col_in;
         row_ff <= row_in;
         pb_ff <= pb_in;
         bitpos_ff <= bitpos_in;
         blk_left_ff <= blk_left_in;
         raw_left_ff <= raw_left_in;
         idx_ff <= idx_in;
         hdr_start_ff <= hdr_start_in;
         filt_ff <= filt_in;
         pack_ff <= pack_in;
         tail_ff <= tail_in;
         fin_ff <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      h_ff <= h_in;
      dc_ff <= dc_in;
      stride_ff <= stride_in;
      raw_ff <= raw_in;
      idat_len_ff <= idat_len_in;
      pack_byte_ff <= pack_byte_in;
      tail_byte_ff <= tail_byte_in;
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

endmodule

FILE: hdl/greyscale_png_stored_encoder.sv
// Top level of the greyscale PNG encoder with stored deflate blocks.
// Depends on gpse_pkg, gpse_front and gpse_back.
//
// A start transaction produces the PNG signature, IHDR, the IDAT length and type,
// the zlib header and the first stored-block header (48 bytes, after the length
// arithmetic of ST_CALC1 to ST_CALC3 on the one multiplier); each pixel transaction
// produces 0 to 2 raw bytes, each preceded by a 5-byte block header when a
// 65535-byte block fills, and the last pixel adds a 20-byte trailer. The byte
// sequencer emits one byte per cycle inside a sequence while the output is not
// stalled; it fetches each queued transaction in ST_IDLE, passes through ST_NEXT
// before each raw byte and closes the transaction in ST_NEXT. A queue of
// QUEUE_DEPTH transactions lets input arrive while bytes drain.
module greyscale_png_stored_encoder import gpse_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [DIM_W-1:0] csr_wdata
);
   cfg_type        cfg_ff, cfg_in;
   queue_head_type head;
   logic           pop;
   phase_type      phase;

   always_comb begin
      cfg_in = cfg_ff;
      // writes are dropped while an image is in progress
      if (csr_we && phase != PH_PIXELS) begin
         case (csr_index)
            CSR_WIDTH:  cfg_in.width = csr_wdata;
            CSR_HEIGHT: cfg_in.height = csr_wdata;
            CSR_DEPTH:  cfg_in.depth_code = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width <= 15'd1;
         cfg_ff.height <= 15'd1;
         cfg_ff.depth_code <= 2'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gpse_front #(.QDEPTH(QUEUE_DEPTH)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .head(head), .pop(pop)
   );

   gpse_back u_back (
      .clock(clock), .reset(reset),
      .head(head), .pop(pop), .cfg(cfg_ff), .phase(phase),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.file_end |-> rsp_payload.run_last)
      else $error("file end without run end");

   a_done_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.file_end |-> phase != PH_IDLE)
      else $error("file end while no image was started");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue popped while empty");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for greyscale_png_stored_encoder: predicts the PNG byte stream
// from its own copy of the encoder state and compares every output transaction.
// Depends on gpse_pkg and the encoder RTL.
module tb;
   import gpse_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 60;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = CSR_WIDTH;
   logic [DIM_W-1:0] csr_wdata = '0;

   greyscale_png_stored_encoder u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // encoder shadow state
   logic [DIM_W-1:0] img_w = 15'd1, img_h = 15'd1;
   logic [1:0]       depth_log = 2'd3;
   logic [31:0]      idat_crc = '1;
   int unsigned      adl_lo = 1, adl_hi = 0;
   int unsigned      col_cnt = 0, row_cnt = 0, bit_pos = 0;
   logic [7:0]       pack_byte = '0;
   int unsigned      block_left = 0, raw_left = 0;
   phase_type        enc_phase = PH_IDLE;

   rsp_type     pending_bytes[$];
   int          errors = 0;
   int          bytes_checked = 0;
   int          images_done = 0;
   int          cycles = 0;
   int          stall_left = 0;
   bit          no_idle = 0;

   function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      c = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) c = c[0] ? (32'hEDB88320 ^ (c >> 1)) : (c >> 1);
      return c;
   endfunction

   function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > 16384) return 16384;
      return v;
   endfunction

   function automatic void push_byte(logic [7:0] b);
      rsp_type r;
      r.out_byte = b;
      r.run_last = 1'b0;
      r.file_end = 1'b0;
      pending_bytes.insert(pending_bytes.size(), r);
   endfunction

   function automatic void push_word(logic [31:0] v);
      push_byte(v[31:24]); push_byte(v[23:16]); push_byte(v[15:8]); push_byte(v[7:0]);
   endfunction

   function automatic void push_idat(logic [7:0] b);
      push_byte(b);
      idat_crc = crc_step(idat_crc, b);
   endfunction

   function automatic void push_block_header();
      int unsigned len;
      logic [15:0] nlen;
      len = (raw_left < 65535) ? raw_left : 65535;
      nlen = ~len[15:0];
      push_idat((raw_left <= 65535) ? 8'd1 : 8'd0);
      push_idat(len[7:0]); push_idat(len[15:8]);
      push_idat(nlen[7:0]); push_idat(nlen[15:8]);
      block_left = len;
   endfunction

   function automatic void push_raw(logic [7:0] b);
      if (block_left == 0) push_block_header();
      push_idat(b);
      adl_lo = (adl_lo + b) % 65521;
      adl_hi = (adl_hi + adl_lo) % 65521;
      block_left = (block_left - 1) & 32'hFFFF;
      raw_left = (raw_left - 1) & 32'h1FFFFFFF;
   endfunction

   function automatic void predict_start();
      logic [7:0]  sig[8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
      logic [7:0]  ihdr[17];
      int unsigned w, h, bits, stride, raw, blocks;
      logic [31:0] c;
      w = clamp_dim(img_w);
      h = clamp_dim(img_h);
      bits = 1 << depth_log;
      stride = (w * bits + 7) / 8;
      raw = h * (1 + stride);
      blocks = (raw + 65534) / 65535;
      ihdr = '{8'h49, 8'h48, 8'h44, 8'h52, 8'h00, 8'h00, w[15:8], w[7:0], 8'h00, 8'h00,
               h[15:8], h[7:0], bits[7:0], 8'h00, 8'h00, 8'h00, 8'h00};
      foreach (sig[i]) push_byte(sig[i]);
      push_word(32'd13);
      c = '1;
      foreach (ihdr[i]) begin
         push_byte(ihdr[i]);
         c = crc_step(c, ihdr[i]);
      end
      push_word(~c);
      push_word(2 + 5 * blocks + raw + 4);
      idat_crc = '1;
      push_idat("I"); push_idat("D"); push_idat("A"); push_idat("T");
      push_idat(8'h78); push_idat(8'h01);
      adl_lo = 1; adl_hi = 0;
      col_cnt = 0; row_cnt = 0; pack_byte = '0; bit_pos = 0;
      raw_left = raw & 32'h1FFFFFFF;
      push_block_header();
      enc_phase = PH_PIXELS;
   endfunction

   function automatic void predict_trailer();
      logic [31:0] c;
      push_idat(adl_hi[15:8]); push_idat(adl_hi[7:0]);
      push_idat(adl_lo[15:8]); push_idat(adl_lo[7:0]);
      push_word(~idat_crc);
      push_word(32'd0);
      c = '1;
      push_byte("I"); push_byte("E"); push_byte("N"); push_byte("D");
      c = crc_step(c, "I"); c = crc_step(c, "E"); c = crc_step(c, "N"); c = crc_step(c, "D");
      push_word(~c);
      pending_bytes[$].file_end = 1'b1;
      enc_phase = PH_DONE;
      images_done++;
   endfunction

   function automatic void predict_pixel(logic [7:0] v);
      int unsigned bits;
      logic [7:0]  sample;
      bits = 1 << depth_log;
      if (col_cnt == 0) push_raw(8'h00);
      sample = v & 8'((9'd1 << bits) - 9'd1);
      pack_byte = pack_byte | (sample << (8 - bits - bit_pos));
      bit_pos += bits;
      if (bit_pos >= 8) begin
         push_raw(pack_byte);
         pack_byte = '0;
         bit_pos = 0;
      end
      col_cnt++;
      if (col_cnt >= clamp_dim(img_w)) begin
         if (bit_pos != 0) push_raw(pack_byte);
         pack_byte = '0; bit_pos = 0; col_cnt = 0;
         row_cnt++;
         if (row_cnt >= clamp_dim(img_h)) predict_trailer();
      end
      col_cnt &= 32'h3FFF;
      row_cnt &= 32'h3FFF;
   endfunction

   function automatic void predict_transaction(req_type t);
      int n0;
      n0 = pending_bytes.size();
      if (t.action == ACT_START) predict_start();
      else if (enc_phase == PH_PIXELS) predict_pixel(t.pixel_value);
      if (pending_bytes.size() > n0) pending_bytes[$].run_last = 1'b1;
   endfunction

   // result side: stall pattern and checking
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d bytes still expected", $time, pending_bytes.size());
         $display("Some tests failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected byte: expected none, actual %h", $time, rsp_payload);
         end else begin
            rsp_type e;
            e = pending_bytes.pop_front();
            bytes_checked++;
            if (e.out_byte !== rsp_payload.out_byte) begin
               errors++;
               $display("%0t: out_byte expected %h actual %h", $time, e.out_byte,
                        rsp_payload.out_byte);
            end
            if (e.run_last !== rsp_payload.run_last) begin
               errors++;
               $display("%0t: run_last expected %b actual %b", $time, e.run_last,
                        rsp_payload.run_last);
            end
            if (e.file_end !== rsp_payload.file_end) begin
               errors++;
               $display("%0t: file_end expected %b actual %b", $time, e.file_end,
                        rsp_payload.file_end);
            end
         end
         stall_left = no_idle ? 0 : $urandom_range(0, 19);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(logic act, logic [7:0] value);
      int gap;
      req_type t;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      t.action = act;
      t.pixel_value = value;
      req_valid <= 1'b1;
      req_payload <= t;
      do @(posedge clock); while (req_stall);
      predict_transaction(t);
   endtask

   // hold input until all expected bytes are out, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_cfg(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic [1:0] d);
      csr_we <= 1'b1; csr_index <= CSR_WIDTH; csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_HEIGHT; csr_wdata <= h;
      @(posedge clock);
      csr_index <= CSR_DEPTH; csr_wdata <= {13'd0, d};
      @(posedge clock);
      csr_we <= 1'b0;
      if (enc_phase != PH_PIXELS) begin
         img_w = w; img_h = h; depth_log = d;
      end
   endtask

   task automatic run_image(int unsigned w, int unsigned h);
      send_item(ACT_START, 8'($urandom_range(0, 255)));
      repeat (w * h) send_item(ACT_PIXEL, 8'($urandom_range(0, 255)));
   endtask

   // reset values, pixels ignored outside an image
   task automatic test_reset_defaults();
      send_item(ACT_PIXEL, 8'hA5);
      send_item(ACT_START, 8'h00);
      send_item(ACT_PIXEL, 8'hFF);
      send_item(ACT_PIXEL, 8'h5A);
      drain();
   endtask

   // every depth, odd width so rows below 8 bits per sample end on a partial byte, extreme sample values
   task automatic test_depths();
      for (int d = 0; d < 4; d++) begin
         write_cfg(15'd3, 15'd2, d[1:0]);
         send_item(ACT_START, 8'hFF);
         send_item(ACT_PIXEL, 8'hFF);
         send_item(ACT_PIXEL, 8'h00);
         send_item(ACT_PIXEL, 8'hAA);
         send_item(ACT_PIXEL, 8'h55);
         send_item(ACT_PIXEL, 8'hFF);
         send_item(ACT_PIXEL, 8'h01);
         drain();
      end
   endtask

   // zero dimensions count as one
   task automatic test_zero_dims();
      write_cfg(15'd0, 15'd0, 2'd1);
      send_item(ACT_START, 8'h00);
      send_item(ACT_PIXEL, 8'hC3);
      drain();
   endtask

   task automatic test_random_images();
      int items;
      int unsigned w, h;
      items = 0;
      while (items < 85) begin
         w = $urandom_range(1, 9);
         h = $urandom_range(1, 4);
         no_idle = ($urandom_range(0, 3) == 0);
         write_cfg(($urandom_range(0, 7) == 0) ? 15'($urandom_range(17000, 32767)) : 15'(w),
                   15'(h), 2'($urandom_range(0, 3)));
         w = clamp_dim(img_w);
         if (w > 9) write_cfg(15'd2, 15'(h), depth_log);
         w = clamp_dim(img_w);
         // sometimes abandon an image partway through
         if ($urandom_range(0, 4) == 0) begin
            send_item(ACT_START, 8'h00);
            repeat ($urandom_range(0, w * h - 1))
               send_item(ACT_PIXEL, 8'($urandom_range(0, 255)));
         end
         run_image(w, h);
         items += w * h + 1;
         if ($urandom_range(0, 3) == 0) send_item(ACT_PIXEL, 8'($urandom_range(0, 255)));
         drain();
      end
      no_idle = 0;
   endtask

   // largest sizes, clamped in IHDR, image left unfinished after an abandon
   task automatic test_max_dims();
      write_cfg(15'h7FFF, 15'h7FFF, 2'd3);
      send_item(ACT_START, 8'h00);
      repeat (5) send_item(ACT_PIXEL, 8'($urandom_range(0, 255)));
      send_item(ACT_START, 8'h00);
      repeat (3) send_item(ACT_PIXEL, 8'($urandom_range(0, 255)));
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_depths();
      test_zero_dims();
      test_random_images();
      test_max_dims();
      $display("Covered %0d complete images and %0d checked bytes over all depths,",
               images_done, bytes_checked);
      $display("clamped and zero dimensions, abandoned images and ignored pixels.");
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
